FILE: src/dgch_pkg.sv
// Shared types, widths and codes for the dual gated counter history block.
package dgch_pkg;

    localparam int HISTORY_DEPTH_DEF = 32;

    localparam int OP_W        = 2;
    localparam int SAMPLE_W    = 32;
    localparam int TOTAL_W     = 64;
    localparam int GOAL_W      = 16;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 16;

    localparam logic [GOAL_W-1:0] GOAL_RESET = GOAL_W'(1);

    typedef enum logic [OP_W-1:0] {
        OP_TICK  = 2'd0,
        OP_POP_A = 2'd1,
        OP_POP_B = 2'd2
    } op_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_GOAL_A = 1'b0,
        REG_GOAL_B = 1'b1
    } reg_index_t;

    // Per-channel command for the request in flight
    typedef struct packed {
        logic tick;
        logic pop;
    } chan_ctrl_t;

    // Per-channel result for the request in flight
    typedef struct packed {
        logic               done;
        logic [TOTAL_W-1:0] total;
        logic               pop_ok;
        logic [TOTAL_W-1:0] pop_value;
    } chan_res_t;

endpackage

FILE: src/dgch_if.sv
// Request and response channel interfaces with valid/ready handshake.
interface dgch_req_if;
    logic                          valid;
    logic                          ready;
    logic [dgch_pkg::OP_W-1:0]     operation;
    logic [dgch_pkg::SAMPLE_W-1:0] count_a;
    logic [dgch_pkg::SAMPLE_W-1:0] count_b;

    modport source (output valid, output operation, output count_a, output count_b,
                    input ready);
    modport sink   (input valid, input operation, input count_a, input count_b,
                    output ready);
endinterface

interface dgch_rsp_if;
    logic                         valid;
    logic                         ready;
    logic                         pop_ok;
    logic [dgch_pkg::TOTAL_W-1:0] pop_value;
    logic                         done_a;
    logic [dgch_pkg::TOTAL_W-1:0] total_a;
    logic                         done_b;
    logic [dgch_pkg::TOTAL_W-1:0] total_b;

    modport source (output valid, output pop_ok, output pop_value, output done_a,
                    output total_a, output done_b, output total_b, input ready);
    modport sink   (input valid, input pop_ok, input pop_value, input done_a,
                    input total_a, input done_b, input total_b, output ready);
endinterface

FILE: src/dgch_chan.sv
// One counter channel: window accumulator, tick count, goal and history FIFO.
module dgch_chan #(
    parameter int DEPTH = dgch_pkg::HISTORY_DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          goal_we,
    input  logic [dgch_pkg::GOAL_W-1:0]   goal_wdata,
    input  dgch_pkg::chan_ctrl_t          ctrl,
    input  logic [dgch_pkg::SAMPLE_W-1:0] sample,
    output dgch_pkg::chan_res_t           res
);

    localparam int IW = $clog2(DEPTH);
    localparam int FW = $clog2(DEPTH + 1);
    localparam logic [FW-1:0] FILL_FULL = FW'(DEPTH);
    localparam logic [IW:0]   DEPTH_X   = (IW + 1)'(DEPTH);
    localparam int TW = dgch_pkg::TOTAL_W;
    localparam int GW = dgch_pkg::GOAL_W;

    // Circular index add, base + off < 2 * DEPTH
    function automatic logic [IW-1:0] wrap_add(input logic [IW-1:0] base,
                                               input logic [FW-1:0] off);
        logic [IW:0] s;
        s = {1'b0, base} + (IW + 1)'(off);
        if (s >= DEPTH_X)
        begin
            s = s - DEPTH_X;
        end
        return s[IW-1:0];
    endfunction

    logic [TW-1:0] sum_reg, sum_next;
    logic [GW-1:0] ticks_reg, ticks_next;
    logic [GW-1:0] goal_reg;
    logic [FW-1:0] fill_reg, fill_next;
    logic [IW-1:0] oldest_reg, oldest_next;
    logic [TW-1:0] head_reg;
    logic [TW-1:0] mem [DEPTH];

    logic [GW-1:0] ticks_inc;
    logic [TW-1:0] sum_inc;
    logic          hit;
    logic          full;
    logic          empty;
    logic [IW-1:0] oldest_inc;
    logic [IW-1:0] wr_addr;
    logic          push;
    logic          pop;

    // Window arithmetic
    assign ticks_inc = ticks_reg + GW'(1);
    assign sum_inc   = sum_reg + TW'(sample);
    assign hit       = (ticks_inc == goal_reg);

    // FIFO bookkeeping
    assign full       = (fill_reg == FILL_FULL);
    assign empty      = (fill_reg == '0);
    assign oldest_inc = wrap_add(oldest_reg, FW'(1));
    assign wr_addr    = full ? oldest_reg : wrap_add(oldest_reg, fill_reg);
    assign push       = ctrl.tick && hit;
    assign pop        = ctrl.pop && !empty;

    // Next state
    always_comb
    begin
        sum_next    = sum_reg;
        ticks_next  = ticks_reg;
        fill_next   = fill_reg;
        oldest_next = oldest_reg;
        if (ctrl.tick)
        begin
            sum_next   = hit ? '0 : sum_inc;
            ticks_next = hit ? '0 : ticks_inc;
        end
        if (goal_we)
        begin
            ticks_next = '0;
        end
        if (push)
        begin
            if (full)
            begin
                oldest_next = oldest_inc;
            end
            else
            begin
                fill_next = fill_reg + FW'(1);
            end
        end
        if (pop)
        begin
            oldest_next = oldest_inc;
            fill_next   = fill_reg - FW'(1);
        end
    end

    // Result for this request
    always_comb
    begin
        res.done      = push;
        res.total     = push ? sum_inc : '0;
        res.pop_ok    = pop;
        res.pop_value = pop ? head_reg : '0;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg    <= '0;
            ticks_reg  <= '0;
            goal_reg   <= dgch_pkg::GOAL_RESET;
            fill_reg   <= '0;
            oldest_reg <= '0;
        end
        else
        begin
            sum_reg    <= sum_next;
            ticks_reg  <= ticks_next;
            fill_reg   <= fill_next;
            oldest_reg <= oldest_next;
            if (goal_we)
            begin
                goal_reg <= goal_wdata;
            end
        end
    end

    // History memory; head holds the entry at the next oldest index,
    // forwarded when the push lands on it in the same cycle
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_addr] <= sum_inc;
        end
        if (push && (wr_addr == oldest_next))
        begin
            head_reg <= sum_inc;
        end
        else
        begin
            head_reg <= mem[oldest_next];
        end
    end

endmodule

FILE: src/dual_gated_counter_history_top.sv
// Path: a taken request is held in the input register, then moves to the response register,
// which drives the response valid; a busy response register holds it in the input register.
// Throughput: one request per cycle; the input register and the response
// register each advance whenever the response register is free or drained.
// Pops read a registered copy of each FIFO's oldest entry, so no memory port limits rate.
// Reset: asynchronous, active low; clears accumulators, tick counts, FIFO counts,
// sets both goals to 1. History contents are not cleared.
module dual_gated_counter_history_top #(
    parameter int HISTORY_DEPTH = dgch_pkg::HISTORY_DEPTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    dgch_req_if.sink                         req,
    dgch_rsp_if.source                       rsp,
    input  logic                             cfg_we,
    input  logic [dgch_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [dgch_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    localparam int TW = dgch_pkg::TOTAL_W;
    localparam int SW = dgch_pkg::SAMPLE_W;

    logic                      s1_valid_reg;
    logic [dgch_pkg::OP_W-1:0] s1_op_reg;
    logic [SW-1:0]             s1_count_a_reg;
    logic [SW-1:0]             s1_count_b_reg;
    logic                      s1_fire;

    logic          out_valid_reg;
    logic          out_pop_ok_reg;
    logic [TW-1:0] out_pop_value_reg;
    logic          out_done_a_reg;
    logic [TW-1:0] out_total_a_reg;
    logic          out_done_b_reg;
    logic [TW-1:0] out_total_b_reg;

    dgch_pkg::chan_ctrl_t ctrl_a, ctrl_b;
    dgch_pkg::chan_res_t  res_a, res_b;
    logic                 goal_a_we, goal_b_we;
    logic                 pop_ok;
    logic [TW-1:0]        pop_value;

    // Handshake: input stage advances when the response register frees up
    assign s1_fire   = s1_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !s1_valid_reg || s1_fire;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            s1_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            s1_op_reg      <= req.operation;
            s1_count_a_reg <= req.count_a;
            s1_count_b_reg <= req.count_b;
        end
    end

    // Decode the operation into per-channel commands
    always_comb
    begin
        ctrl_a = '0;
        ctrl_b = '0;
        unique case (s1_op_reg)
            dgch_pkg::OP_TICK:
            begin
                ctrl_a.tick = s1_fire;
                ctrl_b.tick = s1_fire;
            end
            dgch_pkg::OP_POP_A: ctrl_a.pop = s1_fire;
            dgch_pkg::OP_POP_B: ctrl_b.pop = s1_fire;
            default:
            begin
                ctrl_a = '0;
                ctrl_b = '0;
            end
        endcase
    end

    // Decode goal register writes
    assign goal_a_we = cfg_we && (cfg_index == dgch_pkg::REG_GOAL_A);
    assign goal_b_we = cfg_we && (cfg_index == dgch_pkg::REG_GOAL_B);

    dgch_chan #(
        .DEPTH (HISTORY_DEPTH)
    ) u_chan_a (
        .clk        (clk),
        .rst_n      (rst_n),
        .goal_we    (goal_a_we),
        .goal_wdata (cfg_wdata),
        .ctrl       (ctrl_a),
        .sample     (s1_count_a_reg),
        .res        (res_a)
    );

    dgch_chan #(
        .DEPTH (HISTORY_DEPTH)
    ) u_chan_b (
        .clk        (clk),
        .rst_n      (rst_n),
        .goal_we    (goal_b_we),
        .goal_wdata (cfg_wdata),
        .ctrl       (ctrl_b),
        .sample     (s1_count_b_reg),
        .res        (res_b)
    );

    // Merge pop results; at most one channel pops per request
    assign pop_ok    = res_a.pop_ok || res_b.pop_ok;
    assign pop_value = res_a.pop_value | res_b.pop_value;

    // Response register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            out_pop_ok_reg    <= pop_ok;
            out_pop_value_reg <= pop_value;
            out_done_a_reg    <= res_a.done;
            out_total_a_reg   <= res_a.total;
            out_done_b_reg    <= res_b.done;
            out_total_b_reg   <= res_b.total;
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.pop_ok    = out_pop_ok_reg;
    assign rsp.pop_value = out_pop_value_reg;
    assign rsp.done_a    = out_done_a_reg;
    assign rsp.total_a   = out_total_a_reg;
    assign rsp.done_b    = out_done_b_reg;
    assign rsp.total_b   = out_total_b_reg;

    // A response never carries both a pop and a completed window
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> !(rsp.pop_ok && (rsp.done_a || rsp.done_b)))
        else $error("pop and window completion in one response");

    // Totals are zero unless the window completed
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.done_a && !rsp.done_b) |-> (rsp.total_a == '0 && rsp.total_b == '0))
        else $error("nonzero total without completion");

    // Stalled request in the input stage is held
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_fire) |=> (s1_valid_reg && $stable(s1_op_reg)))
        else $error("input stage lost a stalled request");

endmodule

FILE: bench/tb_dual_gated_counter_history_top.sv
// Testbench for the dual gated counter history block: directed and random requests.
module tb_dual_gated_counter_history_top;

    localparam int HIST_DEPTH   = dgch_pkg::HISTORY_DEPTH_DEF;
    localparam int OW           = dgch_pkg::OP_W;
    localparam int SW           = dgch_pkg::SAMPLE_W;
    localparam int TW           = dgch_pkg::TOTAL_W;
    localparam int GW           = dgch_pkg::GOAL_W;
    localparam int IXW          = dgch_pkg::CFG_INDEX_W;
    localparam int DW           = dgch_pkg::CFG_DATA_W;
    localparam int PHASE_COUNT  = 6;
    localparam int PHASE_ITEMS  = 220;
    localparam int STALL_LIMIT  = 1000;
    localparam int HOLD_CYCLES  = 60;
    localparam int EXTREME_RUN  = 40;
    localparam int SETTLE_WAIT  = 4;

    localparam logic [OW-1:0] OP_UNUSED  = 2'd3;
    localparam logic [SW-1:0] SAMPLE_MAX = '1;

    typedef struct packed {
        logic          pop_ok;
        logic [TW-1:0] pop_value;
        logic          done_a;
        logic [TW-1:0] total_a;
        logic          done_b;
        logic [TW-1:0] total_b;
    } window_report_t;

    logic           clk = 1'b0;
    logic           rst_n;
    logic           cfg_we;
    logic [IXW-1:0] cfg_index;
    logic [DW-1:0]  cfg_wdata;

    dgch_req_if req_ch ();
    dgch_rsp_if rsp_ch ();

    dual_gated_counter_history_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // Predicted per-channel state
    logic [TW-1:0] acc_sum  [2];
    logic [GW-1:0] tick_cnt [2];
    logic [GW-1:0] goal_reg [2];
    logic [TW-1:0] hist_mem [2][HIST_DEPTH];
    int            hist_fill [2];
    int            hist_head [2];

    window_report_t pending_reports[$];

    int mismatch_count = 0;
    int idle_pct       = 0;
    int ready_hold     = 0;
    int quiet_cycles   = 0;

    always #5 clk = ~clk;

    // Advance one channel by a tick; close and store the window on a goal match
    function automatic logic close_window(int ch, logic [SW-1:0] sample,
                                          output logic [TW-1:0] total);
        tick_cnt[ch] = tick_cnt[ch] + GW'(1);
        acc_sum[ch]  = acc_sum[ch] + TW'(sample);
        total        = '0;
        if (tick_cnt[ch] != goal_reg[ch])
            return 1'b0;
        tick_cnt[ch] = '0;
        total        = acc_sum[ch];
        if (hist_fill[ch] >= HIST_DEPTH)
        begin
            // full: overwrite the oldest entry
            hist_mem[ch][hist_head[ch]] = acc_sum[ch];
            hist_head[ch] = (hist_head[ch] + 1) % HIST_DEPTH;
        end
        else
        begin
            hist_mem[ch][(hist_head[ch] + hist_fill[ch]) % HIST_DEPTH] = acc_sum[ch];
            hist_fill[ch]++;
        end
        acc_sum[ch] = '0;
        return 1'b1;
    endfunction

    // Work out the report for one accepted request and update the state
    function automatic window_report_t predict_report(logic [OW-1:0] op,
                                                      logic [SW-1:0] a,
                                                      logic [SW-1:0] b);
        window_report_t r;
        int ch;
        r = '0;
        if (op == dgch_pkg::OP_TICK)
        begin
            r.done_a = close_window(0, a, r.total_a);
            r.done_b = close_window(1, b, r.total_b);
        end
        else if (op == dgch_pkg::OP_POP_A || op == dgch_pkg::OP_POP_B)
        begin
            ch = (op == dgch_pkg::OP_POP_A) ? 0 : 1;
            if (hist_fill[ch] > 0)
            begin
                r.pop_ok    = 1'b1;
                r.pop_value = hist_mem[ch][hist_head[ch]];
                hist_head[ch] = (hist_head[ch] + 1) % HIST_DEPTH;
                hist_fill[ch]--;
            end
        end
        return r;
    endfunction

    function automatic void check_field(string name, logic [TW-1:0] want,
                                        logic [TW-1:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            mismatch_count++;
        end
    endfunction

    function automatic logic [SW-1:0] pick_sample();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        if (r == 1)
            return SAMPLE_MAX;
        return SW'($urandom);
    endfunction

    function automatic logic [OW-1:0] pick_op();
        int r;
        r = $urandom_range(0, 99);
        if (r < 58)
            return dgch_pkg::OP_TICK;
        if (r < 77)
            return dgch_pkg::OP_POP_A;
        if (r < 96)
            return dgch_pkg::OP_POP_B;
        return OP_UNUSED;
    endfunction

    function automatic logic [GW-1:0] pick_goal();
        if ($urandom_range(0, 9) < 7)
            return GW'($urandom_range(1, 4));
        return GW'($urandom_range(5, 16));
    endfunction

    // Offer one request, with an optional idle burst first, and hold until taken
    task automatic send_request(logic [OW-1:0] op, logic [SW-1:0] a,
                                logic [SW-1:0] b);
        if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.operation <= op;
        req_ch.count_a   <= a;
        req_ch.count_b   <= b;
        do
            @(posedge clk);
        while (!req_ch.ready);
        pending_reports.push_back(predict_report(op, a, b));
    endtask

    // Drop valid and wait until every outstanding report has arrived
    task automatic drain_reports();
        req_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_reports.size() != 0);
    endtask

    // Write one goal register; only called while the block is idle
    task automatic write_goal(dgch_pkg::reg_index_t idx, logic [GW-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        goal_reg[idx] = value;
        tick_cnt[idx] = '0;
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Empty pops, the unused code, extreme samples and small windows
    task automatic test_empty_and_basic();
        int i;
        idle_pct = 30;
        send_request(dgch_pkg::OP_POP_A, '0, '0);
        send_request(dgch_pkg::OP_POP_B, SAMPLE_MAX, SAMPLE_MAX);
        send_request(OP_UNUSED, SAMPLE_MAX, SAMPLE_MAX);
        send_request(dgch_pkg::OP_TICK, '0, '0);
        send_request(dgch_pkg::OP_TICK, SAMPLE_MAX, SAMPLE_MAX);
        send_request(dgch_pkg::OP_TICK, 32'hAAAA_AAAA, 32'h5555_5555);
        send_request(dgch_pkg::OP_TICK, 32'h5555_5555, 32'hAAAA_AAAA);
        for (i = 0; i < 5; i++)
        begin
            send_request(dgch_pkg::OP_POP_A, pick_sample(), pick_sample());
            send_request(dgch_pkg::OP_POP_B, pick_sample(), pick_sample());
        end
        drain_reports();
        write_goal(dgch_pkg::REG_GOAL_A, GW'(2));
        write_goal(dgch_pkg::REG_GOAL_B, GW'(3));
        for (i = 0; i < 6; i++)
        begin
            send_request(dgch_pkg::OP_TICK, pick_sample(), pick_sample());
            if (i == 2)
                send_request(OP_UNUSED, pick_sample(), pick_sample());
        end
        drain_reports();
    endtask

    // Overfill both histories so the oldest entries get overwritten, then empty them
    task automatic test_history_overwrite();
        int i;
        idle_pct = 20;
        write_goal(dgch_pkg::REG_GOAL_A, GW'(1));
        write_goal(dgch_pkg::REG_GOAL_B, GW'(1));
        for (i = 0; i < HIST_DEPTH + 8; i++)
            send_request(dgch_pkg::OP_TICK, pick_sample(), pick_sample());
        for (i = 0; i < HIST_DEPTH + 2; i++)
        begin
            send_request(dgch_pkg::OP_POP_A, pick_sample(), pick_sample());
            send_request(dgch_pkg::OP_POP_B, pick_sample(), pick_sample());
        end
        drain_reports();
    endtask

    // Goals of zero and of the largest value keep both windows open over a short run
    task automatic test_goal_extremes();
        int i;
        idle_pct = 0;
        write_goal(dgch_pkg::REG_GOAL_A, '0);
        write_goal(dgch_pkg::REG_GOAL_B, '1);
        for (i = 0; i < EXTREME_RUN; i++)
            send_request(dgch_pkg::OP_TICK, SAMPLE_MAX, SAMPLE_MAX);
        send_request(dgch_pkg::OP_POP_A, '0, '0);
        send_request(dgch_pkg::OP_POP_B, '0, '0);
        send_request(dgch_pkg::OP_POP_A, '0, '0);
        drain_reports();
    endtask

    // Hold the response side off so the block fills up and stalls its input
    task automatic test_response_backpressure();
        int i;
        idle_pct = 0;
        write_goal(dgch_pkg::REG_GOAL_A, GW'(2));
        write_goal(dgch_pkg::REG_GOAL_B, GW'(1));
        ready_hold = HOLD_CYCLES;
        for (i = 0; i < 24; i++)
            send_request(pick_op(), pick_sample(), pick_sample());
        drain_reports();
    endtask

    // Random traffic over several goal settings; the last phase runs without idling
    task automatic test_random_windows();
        int phase;
        int i;
        int phase_idle [PHASE_COUNT] = '{25, 0, 50, 10, 35, 0};
        for (phase = 0; phase < PHASE_COUNT; phase++)
        begin
            drain_reports();
            write_goal(dgch_pkg::REG_GOAL_A, pick_goal());
            write_goal(dgch_pkg::REG_GOAL_B, pick_goal());
            idle_pct = phase_idle[phase];
            for (i = 0; i < PHASE_ITEMS; i++)
                send_request(pick_op(), pick_sample(), pick_sample());
        end
        drain_reports();
    endtask

    // Response ready: long hold on request, random stall bursts otherwise
    initial
    begin : rsp_ready_drive
        int gap_left;
        gap_left = 0;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (ready_hold > 0)
            begin
                rsp_ch.ready <= 1'b0;
                ready_hold--;
            end
            else if (gap_left > 0)
            begin
                rsp_ch.ready <= 1'b0;
                gap_left--;
            end
            else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
            begin
                rsp_ch.ready <= 1'b0;
                gap_left = $urandom_range(0, 8);
            end
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    // Compare each accepted report with the oldest prediction
    always @(posedge clk)
    begin : check_report
        window_report_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_reports.size() == 0)
            begin
                $error("report arrived with no request outstanding");
                mismatch_count++;
            end
            else
            begin
                want = pending_reports.pop_front();
                check_field("pop_ok", TW'(want.pop_ok), TW'(rsp_ch.pop_ok));
                check_field("pop_value", want.pop_value, rsp_ch.pop_value);
                check_field("done_a", TW'(want.done_a), TW'(rsp_ch.done_a));
                check_field("total_a", want.total_a, rsp_ch.total_a);
                check_field("done_b", TW'(want.done_b), TW'(rsp_ch.done_b));
                check_field("total_b", want.total_b, rsp_ch.total_b);
            end
        end
    end

    // Stop the run when nothing moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("FAIL dual_gated_counter_history_top");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        int ch;
        int k;
        rst_n            <= 1'b0;
        req_ch.valid     <= 1'b0;
        req_ch.operation <= dgch_pkg::OP_TICK;
        req_ch.count_a   <= '0;
        req_ch.count_b   <= '0;
        cfg_we           <= 1'b0;
        cfg_index        <= dgch_pkg::REG_GOAL_A;
        cfg_wdata        <= '0;
        for (ch = 0; ch < 2; ch++)
        begin
            acc_sum[ch]   = '0;
            tick_cnt[ch]  = '0;
            goal_reg[ch]  = dgch_pkg::GOAL_RESET;
            hist_fill[ch] = 0;
            hist_head[ch] = 0;
            for (k = 0; k < HIST_DEPTH; k++)
                hist_mem[ch][k] = '0;
        end
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_and_basic();
        test_history_overwrite();
        test_goal_extremes();
        test_response_backpressure();
        test_random_windows();

        repeat (SETTLE_WAIT) @(posedge clk);
        if (mismatch_count == 0)
            $display("PASS dual_gated_counter_history_top");
        else
            $display("FAIL dual_gated_counter_history_top");
        $finish;
    end

endmodule

FILE: filelist.f
src/dgch_pkg.sv
src/dgch_if.sv
src/dgch_chan.sv
src/dual_gated_counter_history_top.sv
bench/tb_dual_gated_counter_history_top.sv
